FILE: rtl/wfr_pkg.sv
// ---------------------------------------------------------------------------
// wfr_pkg
// Shared types, register map and reset values for the Wiegand frame receiver.
// ---------------------------------------------------------------------------
package wfr_pkg;

    localparam int MAX_FRAME_BITS_DEF = 64;

    localparam int FB_W   = 7;
    localparam int TICK_W = 24;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [FB_W-1:0]   FRAME_BITS_RST    = 7'd44;
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 24'd50000;
    localparam logic [TICK_W-1:0] HOLDOFF_TICKS_RST = 24'd500000;

    typedef enum logic [1:0] {
        REG_FRAME_BITS    = 2'd0,
        REG_TIMEOUT_TICKS = 2'd1,
        REG_HOLDOFF_TICKS = 2'd2,
        REG_RESERVED      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [FB_W-1:0]   frame_bits;
        logic [TICK_W-1:0] timeout_ticks;
        logic [TICK_W-1:0] holdoff_ticks;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic timed_out;
    } res_t;

endpackage

FILE: rtl/wiegand_frame_receiver.sv
// ---------------------------------------------------------------------------
// wiegand_frame_receiver
// Wiegand line sampler: packs frames, reports timeouts, holds off after one.
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_stall  zero_line, one_line
//  out       source     out_valid/out_stall  frame_value, timed_out
//  cfg       APB slave  psel/penable/pready  paddr, pwdata, prdata
//
//  One sample per cycle unless in_stall; its result is registered.
//  The frame state machine updates once per accepted transaction.
//  in_stall rises only while the skid stage holds a result behind a stalled
//  output register, so two results may queue before input stalls.
//  Reset loads config defaults, clears valid flags and idles the receiver.
// ---------------------------------------------------------------------------
module wiegand_frame_receiver
    import wfr_pkg::*;
#(
    parameter int MAX_FRAME_BITS = MAX_FRAME_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      zero_line,
    input  logic                      one_line,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [MAX_FRAME_BITS-1:0] frame_value,
    output logic                      timed_out,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    cfg_t                      cfg;
    res_t                      res;
    logic [MAX_FRAME_BITS-1:0] res_value;
    logic                      full;
    logic                      accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    wfr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wfr_core #(
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .zero_line (zero_line),
        .one_line  (one_line),
        .cfg       (cfg),
        .res       (res),
        .res_value (res_value)
    );

    wfr_out_buf #(
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (res),
        .res_value   (res_value),
        .full        (full),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_value (frame_value),
        .timed_out   (timed_out)
    );

endmodule

FILE: rtl/wfr_cfg.sv
// ---------------------------------------------------------------------------
// wfr_cfg
// APB register file holding frame length, timeout and holdoff settings.
// ---------------------------------------------------------------------------
module wfr_cfg
    import wfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_bits    <= FRAME_BITS_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
            cfg_reg.holdoff_ticks <= HOLDOFF_TICKS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_FRAME_BITS:    cfg_reg.frame_bits    <= pwdata[FB_W-1:0];
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= pwdata[TICK_W-1:0];
                REG_HOLDOFF_TICKS: cfg_reg.holdoff_ticks <= pwdata[TICK_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_FRAME_BITS:    prdata = DATA_W'(cfg_reg.frame_bits);
            REG_TIMEOUT_TICKS: prdata = DATA_W'(cfg_reg.timeout_ticks);
            REG_HOLDOFF_TICKS: prdata = DATA_W'(cfg_reg.holdoff_ticks);
            default:           prdata = '0;
        endcase
    end

endmodule

FILE: rtl/wfr_core.sv
// ---------------------------------------------------------------------------
// wfr_core
// Frame state machine: bit shifting, frame timer, release wait and holdoff.
// ---------------------------------------------------------------------------
module wfr_core
    import wfr_pkg::*;
#(
    parameter int MAX_FRAME_BITS = MAX_FRAME_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      zero_line,
    input  logic                      one_line,
    input  cfg_t                      cfg,
    output res_t                      res,
    output logic [MAX_FRAME_BITS-1:0] res_value
);

    localparam int BC_W = $clog2(MAX_FRAME_BITS + 1);
    localparam logic [FB_W-1:0] MAX_FB = FB_W'(MAX_FRAME_BITS);
    localparam logic [BC_W-1:0] MAX_BC = BC_W'(MAX_FRAME_BITS);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_LOW,
        PH_RELEASE,
        PH_HOLDOFF
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [MAX_FRAME_BITS-1:0] shift_reg, shift_next;
    logic [BC_W-1:0]           count_reg, count_next;
    logic [TICK_W-1:0]         tick_reg, tick_next;

    logic                      any_low;
    logic                      new_bit;
    logic [TICK_W-1:0]         tick_inc;
    logic [BC_W-1:0]           count_inc;
    logic [FB_W-1:0]           fb_lim;
    logic [BC_W-1:0]           need_bits;
    logic                      hold_done;

    assign any_low   = !zero_line || !one_line;
    assign new_bit   = zero_line;
    assign tick_inc  = (tick_reg == '1) ? tick_reg : tick_reg + 1'b1;
    assign count_inc = (count_reg < MAX_BC) ? count_reg + 1'b1 : count_reg;
    assign hold_done = (tick_reg >= cfg.holdoff_ticks);

    always_comb
    begin
        if (cfg.frame_bits == '0)
            fb_lim = FB_W'(1);
        else if (cfg.frame_bits > MAX_FB)
            fb_lim = MAX_FB;
        else
            fb_lim = cfg.frame_bits;
    end

    assign need_bits = BC_W'(fb_lim);

    always_comb
    begin
        phase_next    = phase_reg;
        shift_next    = shift_reg;
        count_next    = count_reg;
        tick_next     = tick_reg;
        res.valid     = 1'b0;
        res.timed_out = 1'b0;
        res_value     = shift_reg;

        unique case (phase_reg) inside
            PH_IDLE, PH_HOLDOFF:
            begin
                if (phase_reg == PH_HOLDOFF && !hold_done)
                begin
                    tick_next = tick_reg + 1'b1;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    if (any_low)
                    begin
                        shift_next = {{(MAX_FRAME_BITS-1){1'b0}}, new_bit};
                        count_next = BC_W'(1);
                        phase_next = PH_RELEASE;
                    end
                end
            end
            PH_WAIT_LOW, PH_RELEASE:
            begin
                tick_next = tick_inc;
                if (tick_inc >= cfg.timeout_ticks)
                begin
                    res.valid     = 1'b1;
                    res.timed_out = 1'b1;
                    res_value     = '0;
                    shift_next    = '0;
                    count_next    = '0;
                    tick_next     = '0;
                    phase_next    = PH_HOLDOFF;
                end
                else if (phase_reg == PH_WAIT_LOW)
                begin
                    if (any_low)
                    begin
                        shift_next = {shift_reg[MAX_FRAME_BITS-2:0], new_bit};
                        count_next = count_inc;
                        phase_next = PH_RELEASE;
                    end
                end
                else if (!any_low)
                begin
                    if (count_reg >= need_bits)
                    begin
                        res.valid  = 1'b1;
                        shift_next = '0;
                        count_next = '0;
                        tick_next  = '0;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_WAIT_LOW;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (!accept)
            res.valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            shift_reg <= '0;
            count_reg <= '0;
            tick_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            tick_reg  <= tick_next;
        end
    end

endmodule

FILE: rtl/wfr_out_buf.sv
// ---------------------------------------------------------------------------
// wfr_out_buf
// Result register with a skid stage; decouples output stall from input.
// ---------------------------------------------------------------------------
module wfr_out_buf
    import wfr_pkg::*;
#(
    parameter int MAX_FRAME_BITS = MAX_FRAME_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  res_t                      res,
    input  logic [MAX_FRAME_BITS-1:0] res_value,
    output logic                      full,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [MAX_FRAME_BITS-1:0] frame_value,
    output logic                      timed_out
);

    logic                      out_valid_reg;
    logic [MAX_FRAME_BITS-1:0] out_value_reg;
    logic                      out_to_reg;
    logic                      skid_valid_reg;
    logic [MAX_FRAME_BITS-1:0] skid_value_reg;
    logic                      skid_to_reg;
    logic                      out_free;

    assign out_free    = !out_valid_reg || !out_stall;
    assign full        = skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign frame_value = out_value_reg;
    assign timed_out   = out_to_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res.valid;
            end
        end
        else if (res.valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_value_reg <= skid_value_reg;
                out_to_reg    <= skid_to_reg;
            end
            else if (res.valid)
            begin
                out_value_reg <= res_value;
                out_to_reg    <= res.timed_out;
            end
        end
        else if (res.valid)
        begin
            skid_value_reg <= res_value;
            skid_to_reg    <= res.timed_out;
        end
    end

endmodule

FILE: rtl/wfr_checker.sv
// ---------------------------------------------------------------------------
// wfr_checker
// Port-level checks for the Wiegand frame receiver, bound to the top level.
// ---------------------------------------------------------------------------
module wfr_checker
    import wfr_pkg::*;
#(
    parameter int MAX_FRAME_BITS = MAX_FRAME_BITS_DEF
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [MAX_FRAME_BITS-1:0] frame_value,
    input logic                      timed_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(frame_value) && $stable(timed_out))
        else $error("output transaction changed while stalled");

    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> frame_value == '0)
        else $error("timeout transaction carries nonzero frame_value");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without a pending output transaction");

    a_reset_clear: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && !in_stall && (in_valid || !in_valid))
        else $error("output not clear after reset");

endmodule

bind wiegand_frame_receiver wfr_checker #(
    .MAX_FRAME_BITS (MAX_FRAME_BITS)
) u_wfr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_value (frame_value),
    .timed_out   (timed_out)
);

FILE: test/wiegand_frame_receiver_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// wiegand_frame_receiver_tb
// Self-checking bench for the Wiegand frame receiver: line samples are driven
// through the valid/stall input, results are checked field by field against
// a cycle-free frame predictor, and the register file is reprogrammed over
// APB between phases (reset values, a directed table, then random phases with
// well-formed frames, broken frames and line noise at several settings).
// ---------------------------------------------------------------------------
module wiegand_frame_receiver_tb;
    import wfr_pkg::*;

    localparam int FRAME_W    = MAX_FRAME_BITS_DEF;
    localparam int IDLE_LIMIT = 4000;

    typedef enum logic [1:0] {
        RX_IDLE     = 2'd0,
        RX_WAIT_LOW = 2'd1,
        RX_RELEASE  = 2'd2,
        RX_HOLDOFF  = 2'd3
    } rx_phase_t;

    typedef struct packed {
        logic [FRAME_W-1:0] value;
        logic               timed_out;
    } frame_result_t;

    typedef struct {
        logic          zero_line;
        logic          one_line;
        bit            checked;
        frame_result_t result;
    } line_row_t;

    localparam frame_result_t NO_RESULT = '{value: '0, timed_out: 1'b0};

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic                zero_line = 1'b1;
    logic                one_line  = 1'b1;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [FRAME_W-1:0]  frame_value;
    logic                timed_out;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic [FB_W-1:0]     cfg_frame_bits = FRAME_BITS_RST;
    logic [TICK_W-1:0]   cfg_timeout    = TIMEOUT_TICKS_RST;
    logic [TICK_W-1:0]   cfg_holdoff    = HOLDOFF_TICKS_RST;

    logic [FRAME_W-1:0]  rx_shift = '0;
    logic [FB_W-1:0]     rx_count = '0;
    logic [TICK_W-1:0]   rx_ticks = '0;
    rx_phase_t           rx_phase = RX_IDLE;

    frame_result_t       pending_frames [$];
    int unsigned         mismatches  = 0;
    int unsigned         items_sent  = 0;
    int unsigned         idle_cycles = 0;
    bit                  steady_run  = 1'b0;

    // frame 100, timeout with holdoff, then frame 011 started right after holdoff
    line_row_t directed_rows [22] = '{
        '{1'b1, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, 1'b1, 1'b0, NO_RESULT},
        '{1'b1, 1'b1, 1'b1, '{value: 64'd4, timed_out: 1'b0}},
        '{1'b1, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b1, 1'b1, 1'b1, '{value: 64'd0, timed_out: 1'b1}},
        '{1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b1, 1'b0, NO_RESULT},
        '{1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b1, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b1, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, 1'b1, 1'b1, '{value: 64'd3, timed_out: 1'b0}}
    };

    wiegand_frame_receiver dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .zero_line   (zero_line),
        .one_line    (one_line),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_value (frame_value),
        .timed_out   (timed_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 clk = ~clk;

    function automatic int unsigned frame_length();
        if (cfg_frame_bits == 0)
            return 1;
        if (cfg_frame_bits > FRAME_W)
            return FRAME_W;
        return cfg_frame_bits;
    endfunction

    function automatic void clear_frame();
        rx_shift = '0;
        rx_count = '0;
        rx_ticks = '0;
    endfunction

    function automatic void shift_in_bit(input logic zero_low);
        rx_shift = (rx_shift << 1) | FRAME_W'(!zero_low);
        if (rx_count < FRAME_W)
            rx_count++;
        rx_phase = RX_RELEASE;
    endfunction

    function automatic bit predict_sample(input logic z, input logic o,
                                          output frame_result_t res);
        logic zero_low;
        logic any_low;
        zero_low = (z == 1'b0);
        any_low  = zero_low || (o == 1'b0);
        res      = NO_RESULT;
        if (rx_phase == RX_HOLDOFF)
        begin
            if (rx_ticks < cfg_holdoff)
            begin
                rx_ticks++;
                return 1'b0;
            end
            rx_phase = RX_IDLE;
            rx_ticks = '0;
        end
        if (rx_phase == RX_IDLE)
        begin
            if (any_low)
            begin
                clear_frame();
                shift_in_bit(zero_low);
            end
            return 1'b0;
        end
        if (rx_ticks != '1)
            rx_ticks++;
        if (rx_ticks >= cfg_timeout)
        begin
            res.timed_out = 1'b1;
            clear_frame();
            rx_phase = RX_HOLDOFF;
            return 1'b1;
        end
        if (rx_phase == RX_WAIT_LOW)
        begin
            if (any_low)
                shift_in_bit(zero_low);
            return 1'b0;
        end
        if (!any_low)
        begin
            if (rx_count >= frame_length())
            begin
                res.value = rx_shift;
                clear_frame();
                rx_phase = RX_IDLE;
                return 1'b1;
            end
            rx_phase = RX_WAIT_LOW;
        end
        return 1'b0;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic send_sample(input logic z, input logic o,
                               input bit typed, input frame_result_t typed_res);
        frame_result_t res;
        bit            got;
        @(negedge clk);
        while (!steady_run && $urandom_range(0, 99) < 27)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        zero_line <= z;
        one_line  <= o;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        got = predict_sample(z, o, res);
        if (typed)
            pending_frames.push_back(typed_res);
        else if (got)
            pending_frames.push_back(res);
        items_sent++;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_FRAME_BITS:    cfg_frame_bits = data[FB_W-1:0];
            REG_TIMEOUT_TICKS: cfg_timeout    = data[TICK_W-1:0];
            REG_HOLDOFF_TICKS: cfg_holdoff    = data[TICK_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_regs(input logic [FB_W-1:0] fb, input logic [TICK_W-1:0] to,
                                input logic [TICK_W-1:0] ho);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        write_reg(REG_FRAME_BITS, DATA_W'(fb));
        write_reg(REG_TIMEOUT_TICKS, DATA_W'(to));
        write_reg(REG_HOLDOFF_TICKS, DATA_W'(ho));
    endtask

    task automatic send_frame(input int unsigned nbits);
        for (int unsigned b = 0; b < nbits; b++)
        begin
            repeat ($urandom_range(1, 2))
            begin
                case ($urandom_range(0, 2))
                    0:       send_sample(1'b0, 1'b1, 1'b0, NO_RESULT);
                    1:       send_sample(1'b1, 1'b0, 1'b0, NO_RESULT);
                    default: send_sample(1'b0, 1'b0, 1'b0, NO_RESULT);
                endcase
            end
            repeat ($urandom_range(1, 2))
                send_sample(1'b1, 1'b1, 1'b0, NO_RESULT);
        end
    endtask

    task automatic play_phase(input bit reprogram, input logic [FB_W-1:0] fb,
                              input logic [TICK_W-1:0] to, input logic [TICK_W-1:0] ho,
                              input int unsigned n_items, input bit clean);
        int unsigned first;
        int unsigned pick;
        int unsigned need;
        if (reprogram)
        begin
            while (rx_phase != RX_IDLE)
                send_sample(1'b1, 1'b1, 1'b0, NO_RESULT);
            program_regs(fb, to, ho);
        end
        need  = frame_length();
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            pick = clean ? 0 : $urandom_range(0, 99);
            if (pick < 75)
            begin
                send_frame(need);
            end
            else if (pick < 88)
            begin
                send_frame($urandom_range(0, need - 1));
                repeat ($urandom_range(1, 70))
                    send_sample(1'b1, 1'b1, 1'b0, NO_RESULT);
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'b0, NO_RESULT);
            end
        end
    endtask

    always @(negedge clk)
        out_stall <= steady_run ? 1'b0 : ($urandom_range(0, 99) < 27);

    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frames.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result value=%h timed_out=%b",
                                        frame_value, timed_out));
            end
            else
            begin
                want = pending_frames.pop_front();
                if (frame_value !== want.value)
                    flag_mismatch($sformatf("frame_value %h, want %h",
                                            frame_value, want.value));
                if (timed_out !== want.timed_out)
                    flag_mismatch($sformatf("timed_out %b, want %b",
                                            timed_out, want.timed_out));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        play_phase(1'b0, '0, '0, '0, 1, 1'b1);

        program_regs(7'd3, 24'd6, 24'd3);
        foreach (directed_rows[i])
            send_sample(directed_rows[i].zero_line, directed_rows[i].one_line,
                        directed_rows[i].checked, directed_rows[i].result);

        play_phase(1'b1, 7'd1, 24'd0, 24'd0, 100, 1'b0);
        play_phase(1'b1, 7'd0, 24'($urandom_range(4, 30)), 24'($urandom_range(0, 10)),
                   80, 1'b0);
        play_phase(1'b1, 7'd64, 24'hFFFFFF, 24'hFFFFFF, 1, 1'b1);
        steady_run = 1'b1;
        play_phase(1'b1, 7'd127, 24'hFFFFFF, 24'($urandom_range(0, 15)), 1, 1'b1);
        steady_run = 1'b0;
        repeat (3)
            play_phase(1'b1, 7'($urandom_range(2, 12)), 24'($urandom_range(1, 60)),
                       24'($urandom_range(0, 15)), 60, 1'b0);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_frames.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
rtl/wfr_pkg.sv
rtl/wfr_cfg.sv
rtl/wfr_core.sv
rtl/wfr_out_buf.sv
rtl/wiegand_frame_receiver.sv
rtl/wfr_checker.sv
test/wiegand_frame_receiver_tb.sv
